>>> hw/rtl/mpe_pkg.sv
// mpe_pkg: shared widths, constants, command/status structs and saturation helpers
// for the midpoint ellipse point generator; used by mpe_ctrl, mpe_dp and the top level.
// no dependencies.
package mpe_pkg;

    localparam int AXIS_W   = 10;
    localparam int CENTER_W = 11;
    localparam int COORD_W  = 13;
    localparam int SQ_W     = 2 * AXIS_W;          // squared semi-axis
    localparam int WALK_P_W = SQ_W + AXIS_W;       // squared axis times walk coordinate
    localparam int TERM_W   = 2 * (AXIS_W + 1);    // square of an 11-bit term
    localparam int FAC_W    = TERM_W + 2;          // term scaled by 4
    localparam int PROD_W   = SQ_W + FAC_W;        // decision partial product
    localparam int AB4_W    = 2 * SQ_W + 2;        // 4*a*a*b*b
    localparam int DEC_W    = PROD_W + 1;          // decision sum

    localparam int IN_DATA_W  = 48;                // 42 field bits padded to bytes
    localparam int OUT_DATA_W = 72;

    localparam logic [AXIS_W-1:0]   AXIS_MAX   = 10'd1023;
    localparam logic [CENTER_W-1:0] CENTER_MAX = 11'd2047;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef struct packed {
        logic load_start;   // capture centre and axes, reset the walk
        logic calc_axes;    // square the semi-axes
        logic calc_ab;      // form 4*a2*b2
        logic calc_mul1;    // region products and term squares
        logic calc_cmp;     // region decision and factor select
        logic calc_mul2;    // decision partial products
        logic commit;       // apply one step to the walk
        logic emit_point;   // load a point into the output register
        logic emit_null;    // load an empty result into the output register
    } mpe_cmd_t;

    typedef struct packed {
        logic active;
        logic out_free;
    } mpe_stat_t;

    function automatic logic [AXIS_W-1:0] sat_axis(input logic [AXIS_W-1:0] v);
        sat_axis = (v > AXIS_MAX) ? AXIS_MAX : v;
    endfunction

    function automatic logic [CENTER_W-1:0] sat_center(input logic [CENTER_W-1:0] v);
        sat_center = (v > CENTER_MAX) ? CENTER_MAX : v;
    endfunction

endpackage

>>> hw/rtl/mpe_ctrl.sv
// mpe_ctrl: sequencing state machine of the ellipse point generator
// depends on mpe_pkg; drives the command struct of mpe_dp and reads its status.
module mpe_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic               kind,
    output mpe_pkg::mpe_cmd_t  cmd,
    input  mpe_pkg::mpe_stat_t stat
);
    import mpe_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_AXES = 8'b0000_0010,
        ST_AB   = 8'b0000_0100,
        ST_MUL1 = 8'b0000_1000,
        ST_CMP  = 8'b0001_0000,
        ST_MUL2 = 8'b0010_0000,
        ST_DEC  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   null_reg, null_next;
    logic   accept;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        null_next  = null_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_START)
                    begin
                        cmd.load_start = 1'b1;
                        null_next      = 1'b0;
                        state_next     = ST_AXES;
                    end
                    else if (stat.active)
                    begin
                        null_next  = 1'b0;
                        state_next = ST_MUL1;
                    end
                    else
                    begin
                        null_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_AXES:
            begin
                cmd.calc_axes = 1'b1;
                state_next    = ST_AB;
            end
            ST_AB:
            begin
                cmd.calc_ab = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_MUL1:
            begin
                cmd.calc_mul1 = 1'b1;
                state_next    = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.calc_cmp = 1'b1;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.calc_mul2 = 1'b1;
                state_next    = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.commit = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the result
                if (stat.out_free)
                begin
                    cmd.emit_point = !null_reg;
                    cmd.emit_null  = null_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            null_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            null_reg  <= null_next;
        end
    end

    // one request at a time: an accepted request closes the input until its result is out
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("mpe_ctrl: input accepted while a request is in progress");

endmodule

>>> hw/rtl/mpe_dp.sv
// mpe_dp: datapath of the ellipse point generator: axis registers, walk position,
// decision multipliers and the output register. depends on mpe_pkg.
module mpe_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mpe_pkg::mpe_cmd_t                   cmd,
    output mpe_pkg::mpe_stat_t                  stat,
    input  logic [mpe_pkg::CENTER_W-1:0]        center_x,
    input  logic [mpe_pkg::CENTER_W-1:0]        center_y,
    input  logic [mpe_pkg::AXIS_W-1:0]          semi_axis_a,
    input  logic [mpe_pkg::AXIS_W-1:0]          semi_axis_b,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mpe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);
    import mpe_pkg::*;

    logic [CENTER_W-1:0] cx_reg, cy_reg;
    logic [AXIS_W-1:0]   a_reg, b_reg;
    logic [AXIS_W-1:0]   x_reg, y_reg, x_next, y_next;
    logic                active_reg;
    logic [SQ_W-1:0]     a2_reg, b2_reg;
    logic [AB4_W-1:0]    ab4_reg;
    logic [WALK_P_W-1:0] bx_reg, ay_reg;
    logic [TERM_W-1:0]   t1_reg, t2_reg, s1_reg;
    logic [SQ_W-1:0]     s2_reg;
    logic                region1_reg;
    logic [FAC_W-1:0]    fb_reg, fa_reg;
    logic [PROD_W-1:0]   pb_reg, pa_reg;

    logic                  out_valid_reg;
    logic                  out_user_reg;
    logic                  out_last_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [SQ_W-1:0]     a2_p, b2_p;
    logic [2*SQ_W-1:0]   ab_p;
    logic [WALK_P_W-1:0] bx_p, ay_p;
    logic [AXIS_W:0]     x_inc, x_dbl, y_dbl;
    logic [AXIS_W-1:0]   y_dec;
    logic [TERM_W-1:0]   t1_p, t2_p, s1_p;
    logic [SQ_W-1:0]     s2_p;
    logic                region1;
    logic [PROD_W-1:0]   pb_p, pa_p;
    logic [DEC_W-1:0]    dec_sum;
    logic                dec_pos;
    logic [COORD_W-1:0]  x_right, x_left, y_down, y_up;

    assign a2_p = a_reg * a_reg;
    assign b2_p = b_reg * b_reg;
    assign ab_p = a2_reg * b2_reg;

    // region-1 terms (x+1)^2, (2y-1)^2; region-2 terms (2x+1)^2, (y-1)^2
    assign x_inc = {1'b0, x_reg} + 11'd1;
    assign x_dbl = {x_reg, 1'b1};
    assign y_dbl = {y_reg, 1'b0} - 11'd1;
    assign y_dec = y_reg - 10'd1;
    assign bx_p  = b2_reg * x_reg;
    assign ay_p  = a2_reg * y_reg;
    assign t1_p  = x_inc * x_inc;
    assign t2_p  = y_dbl * y_dbl;
    assign s1_p  = x_dbl * x_dbl;
    assign s2_p  = y_dec * y_dec;

    assign region1 = bx_reg < ay_reg;
    assign pb_p    = b2_reg * fb_reg;
    assign pa_p    = a2_reg * fa_reg;

    // decision is positive when the scaled ellipse function exceeds 4*a2*b2
    assign dec_sum = {1'b0, pb_reg} + {1'b0, pa_reg};
    assign dec_pos = dec_sum > {{(DEC_W-AB4_W){1'b0}}, ab4_reg};

    always_comb
    begin
        if (region1_reg)
        begin
            x_next = x_reg + 10'd1;
            y_next = dec_pos ? y_dec : y_reg;
        end
        else
        begin
            x_next = dec_pos ? x_reg : x_reg + 10'd1;
            y_next = y_dec;
        end
    end

    assign x_right = {2'b00, cx_reg} + {3'b000, x_reg};
    assign x_left  = {2'b00, cx_reg} - {3'b000, x_reg};
    assign y_down  = {2'b00, cy_reg} + {3'b000, y_reg};
    assign y_up    = {2'b00, cy_reg} - {3'b000, y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg        <= '0;
            cy_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                cx_reg     <= sat_center(center_x);
                cy_reg     <= sat_center(center_y);
                a_reg      <= sat_axis(semi_axis_a);
                b_reg      <= sat_axis(semi_axis_b);
                x_reg      <= '0;
                y_reg      <= sat_axis(semi_axis_b);
                active_reg <= 1'b1;
            end
            else if (cmd.commit)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            if (cmd.emit_point && (y_reg == '0))
                active_reg <= 1'b0;
            if (cmd.emit_point || cmd.emit_null)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_axes)
        begin
            a2_reg <= a2_p;
            b2_reg <= b2_p;
        end
        if (cmd.calc_ab)
            ab4_reg <= {ab_p, 2'b00};
        if (cmd.calc_mul1)
        begin
            bx_reg <= bx_p;
            ay_reg <= ay_p;
            t1_reg <= t1_p;
            t2_reg <= t2_p;
            s1_reg <= s1_p;
            s2_reg <= s2_p;
        end
        if (cmd.calc_cmp)
        begin
            region1_reg <= region1;
            fb_reg      <= region1 ? {t1_reg, 2'b00} : {2'b00, s1_reg};
            fa_reg      <= region1 ? {2'b00, t2_reg} : {2'b00, s2_reg, 2'b00};
        end
        if (cmd.calc_mul2)
        begin
            pb_reg <= pb_p;
            pa_reg <= pa_p;
        end
        if (cmd.emit_point)
        begin
            out_data_reg <= {y_up, y_down, x_left, x_right, y_reg, x_reg};
            out_user_reg <= 1'b1;
            out_last_reg <= (y_reg == '0);
        end
        else if (cmd.emit_null)
        begin
            out_data_reg <= '0;
            out_user_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
    end

    assign stat.active   = active_reg;
    assign stat.out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // an empty result carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_user_reg) |-> (out_data_reg == '0) && !out_last_reg)
        else $error("mpe_dp: empty result carries nonzero fields");

    // the last marker sits exactly on the point with zero y offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg) |->
            (out_last_reg == (out_data_reg[2*AXIS_W-1:AXIS_W] == '0)))
        else $error("mpe_dp: last marker does not match y offset");

    // a step moves x forward by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (x_reg == $past(x_reg)) || (x_reg == $past(x_reg) + 10'd1))
        else $error("mpe_dp: x moved by more than one");

    // a step always moves the walk
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (x_reg != $past(x_reg)) || (y_reg != $past(y_reg)))
        else $error("mpe_dp: step left the walk unchanged");

endmodule

>>> hw/rtl/midpoint_ellipse_point_generator.sv
// midpoint_ellipse_point_generator: top level of the midpoint ellipse walker
// depends on mpe_pkg, mpe_ctrl and mpe_dp.
//
// usage: each request on the s_axis channel yields exactly one result on m_axis.
// a start request (tuser = 0) loads centre and semi-axes (saturated to the axis and
// centre limits) and returns the first point (0, b). an advance request (tuser = 1)
// runs one midpoint step in region 1 or region 2 and returns the next point. a
// result carries the first-quadrant offsets and the four mirrored coordinates; tlast
// marks the point with zero y offset, after which the walk goes idle. an advance
// request while idle returns a result with tuser = 0 and all-zero data.
// timing: one request at a time. a start squares the semi-axes and forms 4*a2*b2
// before its point is emitted; an advance runs two multiply stages, a compare stage
// and the decision add before the emit, and an advance while idle goes straight to
// the emit.
// the result sits in an output register, so a new request is taken while an earlier
// result waits; when the receiver stalls with a full output register, the next
// result holds inside the block and s_axis_tready stays low.
// reset clears the walk to idle with the semi-axis, centre and walk registers at zero.
module midpoint_ellipse_point_generator
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // center_x[10:0], center_y[21:11], semi_axis_a[31:22], semi_axis_b[41:32], zero pad
    input  logic [mpe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // offset_x[9:0], offset_y[19:10], x_right[32:20], x_left[45:33],
    // y_down[58:46], y_up[71:59]
    output logic [mpe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // valid_res
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import mpe_pkg::*;

    mpe_cmd_t  cmd;
    mpe_stat_t stat;

    logic [CENTER_W-1:0] center_x, center_y;
    logic [AXIS_W-1:0]   semi_axis_a, semi_axis_b;

    assign center_x    = s_axis_tdata[CENTER_W-1:0];
    assign center_y    = s_axis_tdata[2*CENTER_W-1:CENTER_W];
    assign semi_axis_a = s_axis_tdata[2*CENTER_W+AXIS_W-1:2*CENTER_W];
    assign semi_axis_b = s_axis_tdata[2*CENTER_W+2*AXIS_W-1:2*CENTER_W+AXIS_W];

    mpe_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .kind          (s_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

    mpe_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .center_x      (center_x),
        .center_y      (center_y),
        .semi_axis_a   (semi_axis_a),
        .semi_axis_b   (semi_axis_b),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
